[rtl/cqt_pkg.sv]
// ----------------------------------------------------------------------------
// cqt_pkg
// Shared types, constants and table builder of the cylinder quad tessellator.
// ----------------------------------------------------------------------------
package cqt_pkg;

    localparam int SINE_TABLE_BITS     = 10;
    localparam int MAX_HEIGHT_SEGMENTS = 255;
    localparam int MAX_ANGLE_SEGMENTS  = 255;

    localparam int AW      = SINE_TABLE_BITS;
    localparam int QUARTER = 1 << (SINE_TABLE_BITS - 2);
    localparam int VALW    = 15;
    localparam int ONE_Q14  = 16384;
    localparam int HALF_Q14 = 8192;

    localparam int DIV_DW = 23;
    localparam int DIV_VW = 8;
    localparam int QDEPTH = 4;
    localparam int QPTRW  = 2;

    localparam logic [1:0] OP_SIDE   = 2'd0;
    localparam logic [1:0] OP_BOTTOM = 2'd1;
    localparam logic [1:0] OP_TOP    = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    localparam logic [1:0] CORNER_TL = 2'd0;
    localparam logic [1:0] CORNER_BL = 2'd1;
    localparam logic [1:0] CORNER_TR = 2'd2;
    localparam logic [1:0] CORNER_BR = 2'd3;

    localparam logic [1:0] SLOT_A0 = 2'd0;
    localparam logic [1:0] SLOT_A1 = 2'd1;
    localparam logic [1:0] SLOT_V0 = 2'd2;
    localparam logic [1:0] SLOT_V1 = 2'd3;

    localparam logic REG_HEIGHT = 1'b0;
    localparam logic REG_ANGLE  = 1'b1;

    typedef struct packed {
        logic            err;
        logic [1:0]      part;
        logic [AW-1:0]   a0;
        logic [AW-1:0]   a1;
        logic [VALW-1:0] v0;
        logic [VALW-1:0] v1;
    } quad_t;

    typedef struct packed {
        logic [1:0] slot;
        logic       err;
        logic [1:0] part;
    } div_tag_t;

    typedef logic [VALW-1:0] qtab_t [QUARTER+1];

    function automatic qtab_t build_qtab();
        qtab_t       t;
        logic [63:0] x;
        logic [63:0] sum;
        logic [63:0] term;
        logic [63:0] r;
        for (int k = 0; k <= QUARTER; k++) begin
            x    = (64'd1686629713 * 64'(k)) / 64'(QUARTER);
            sum  = x;
            term = x;
            for (int n = 1; n <= 8; n++) begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = term / 64'((2 * n) * (2 * n + 1));
                if ((n % 2) == 1) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
            r = (sum * 64'(ONE_Q14) + (64'd1 << 29)) >> 30;
            if (r > 64'(ONE_Q14)) begin
                r = 64'(ONE_Q14);
            end
            t[k] = VALW'(r);
        end
        return t;
    endfunction

    function automatic logic [1:0] corner_of(logic [2:0] k, logic bottom);
        logic [1:0] c;
        case (k)
            3'd0:    c = bottom ? CORNER_BL : CORNER_TL;
            3'd1:    c = bottom ? CORNER_TL : CORNER_BL;
            3'd2:    c = CORNER_TR;
            3'd3:    c = bottom ? CORNER_BR : CORNER_BL;
            3'd4:    c = bottom ? CORNER_BL : CORNER_BR;
            default: c = CORNER_TR;
        endcase
        return c;
    endfunction

endpackage

[rtl/cqt_div.sv]
// ----------------------------------------------------------------------------
// cqt_div
// Pipelined restoring divider, a few quotient bits per stage, one op a cycle.
// ----------------------------------------------------------------------------
module cqt_div #(
    parameter int DW  = 23,
    parameter int VW  = 8,
    parameter int TW  = 5,
    parameter int BPS = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_vld,
    input  logic [DW-1:0] in_dvd,
    input  logic [VW-1:0] in_dvs,
    input  logic [TW-1:0] in_tag,
    output logic          out_vld,
    output logic [DW-1:0] out_quo,
    output logic [TW-1:0] out_tag
);

    localparam int NS = (DW + BPS - 1) / BPS;
    localparam int PW = NS * BPS;

    logic          vld_reg [NS];
    logic [PW-1:0] qd_reg  [NS];
    logic [VW-1:0] rm_reg  [NS];
    logic [VW-1:0] dv_reg  [NS];
    logic [TW-1:0] tg_reg  [NS];

    genvar i;
    generate
        for (i = 0; i < NS; i++) begin : g_stage
            logic          vld_in;
            logic [PW-1:0] qd_in;
            logic [VW-1:0] rm_in;
            logic [VW-1:0] dv_in;
            logic [TW-1:0] tg_in;
            logic [PW-1:0] qd_next;
            logic [VW-1:0] rm_next;

            if (i == 0) begin : g_first
                assign vld_in = in_vld;
                assign qd_in  = PW'(in_dvd);
                assign rm_in  = '0;
                assign dv_in  = in_dvs;
                assign tg_in  = in_tag;
            end else begin : g_rest
                assign vld_in = vld_reg[i-1];
                assign qd_in  = qd_reg[i-1];
                assign rm_in  = rm_reg[i-1];
                assign dv_in  = dv_reg[i-1];
                assign tg_in  = tg_reg[i-1];
            end

            always_comb begin
                logic [PW-1:0] q;
                logic [VW:0]   t;
                logic [VW-1:0] r;
                q = qd_in;
                r = rm_in;
                for (int j = 0; j < BPS; j++) begin
                    t = {r, q[PW-1]};
                    q = {q[PW-2:0], 1'b0};
                    if (t >= {1'b0, dv_in}) begin
                        t    = t - {1'b0, dv_in};
                        q[0] = 1'b1;
                    end
                    r = t[VW-1:0];
                end
                qd_next = q;
                rm_next = r;
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[i] <= 1'b0;
                end else begin
                    vld_reg[i] <= vld_in;
                end
                qd_reg[i] <= qd_next;
                rm_reg[i] <= rm_next;
                dv_reg[i] <= dv_in;
                tg_reg[i] <= tg_in;
            end
        end
    endgenerate

    assign out_vld = vld_reg[NS-1];
    assign out_quo = qd_reg[NS-1][DW-1:0];
    assign out_tag = tg_reg[NS-1];

endmodule

[rtl/cqt_front.sv]
// ----------------------------------------------------------------------------
// cqt_front
// Accepts requests, checks the indices and works out the edge angles and the
// heights or radii through the shared divider, then queues the quad.
// ----------------------------------------------------------------------------
module cqt_front import cqt_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic [7:0]  height_segments,
    input  logic [7:0]  angle_segments,
    input  logic        q_pop,
    output logic        q_push,
    output quad_t       q_wdata
);

    logic           busy_reg, busy_next;
    logic [1:0]     slot_reg, slot_next;
    logic [7:0]     w_reg, c_reg;
    logic [1:0]     part_reg;
    logic           err_reg;
    logic [QPTRW:0] used_reg, used_next;
    logic [AW-1:0]  a0_reg, a1_reg;
    logic [VALW-1:0] v0_reg;

    logic              accept;
    logic [8:0]        w_ext, c_ext;
    logic [DIV_DW-1:0] ang_dvd, seg_dvd, dvd;
    logic [DIV_VW-1:0] dvs;
    div_tag_t          tag_in, tag_out;
    logic              out_vld;
    logic [DIV_DW-1:0] out_quo;

    assign s_tready = !busy_reg && (used_reg != (QPTRW+1)'(QDEPTH));
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        busy_next = busy_reg;
        slot_next = slot_reg;
        if (accept) begin
            busy_next = 1'b1;
            slot_next = SLOT_A0;
        end else if (busy_reg) begin
            slot_next = slot_reg + 2'd1;
            if (slot_reg == SLOT_V1) begin
                busy_next = 1'b0;
            end
        end
        used_next = used_reg + (QPTRW+1)'(accept) - (QPTRW+1)'(q_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            slot_reg <= SLOT_A0;
            used_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            slot_reg <= slot_next;
            used_reg <= used_next;
        end
        if (accept) begin
            w_reg    <= s_tdata[7:0];
            c_reg    <= s_tdata[15:8];
            part_reg <= s_tuser;
            err_reg  <= (s_tuser == OP_NONE) || (s_tdata[7:0] >= angle_segments)
                        || (s_tdata[15:8] >= height_segments);
        end
    end

    // slots: start angle, next angle, inner/top value, outer/bottom value
    always_comb begin
        w_ext   = slot_reg[0] ? ({1'b0, w_reg} + 9'd1) : {1'b0, w_reg};
        c_ext   = slot_reg[0] ? ({1'b0, c_reg} + 9'd1) : {1'b0, c_reg};
        ang_dvd = (DIV_DW'(w_ext) << AW) + DIV_DW'(angle_segments[7:1]);
        seg_dvd = ((part_reg == OP_SIDE) ? (DIV_DW'(c_ext) << 14) : (DIV_DW'(c_ext) << 13))
                  + DIV_DW'(height_segments[7:1]);
        dvd     = slot_reg[1] ? seg_dvd : ang_dvd;
        dvs     = slot_reg[1] ? height_segments : angle_segments;
        tag_in  = '{slot: slot_reg, err: err_reg, part: part_reg};
    end

    cqt_div #(
        .DW  (DIV_DW),
        .VW  (DIV_VW),
        .TW  ($bits(div_tag_t)),
        .BPS (4)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_vld  (busy_reg),
        .in_dvd  (dvd),
        .in_dvs  (dvs),
        .in_tag  (tag_in),
        .out_vld (out_vld),
        .out_quo (out_quo),
        .out_tag (tag_out)
    );

    always_ff @(posedge aclk) begin
        if (out_vld) begin
            case (tag_out.slot)
                SLOT_A0: a0_reg <= out_quo[AW-1:0];
                SLOT_A1: a1_reg <= out_quo[AW-1:0];
                SLOT_V0: v0_reg <= out_quo[VALW-1:0];
                default: ;
            endcase
        end
    end

    assign q_push  = out_vld && (tag_out.slot == SLOT_V1);
    assign q_wdata = '{err: tag_out.err, part: tag_out.part, a0: a0_reg, a1: a1_reg,
                       v0: v0_reg, v1: out_quo[VALW-1:0]};

endmodule

[rtl/cqt_queue.sv]
// ----------------------------------------------------------------------------
// cqt_queue
// Short queue of prepared quads between front and back.
// ----------------------------------------------------------------------------
module cqt_queue import cqt_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  quad_t wdata,
    input  logic  pop,
    output logic  rvalid,
    output quad_t rdata
);

    quad_t          mem_reg [QDEPTH];
    logic [QPTRW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTRW:0]   count_reg, count_next;

    assign rvalid     = (count_reg != '0);
    assign rdata      = mem_reg[rd_ptr_reg];
    assign count_next = count_reg + (QPTRW+1)'(push) - (QPTRW+1)'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

[rtl/cqt_back.sv]
// ----------------------------------------------------------------------------
// cqt_back
// Walks six corners of a queued quad, or one error item: table lookup, scaling
// multiply, rounding; one vertex a cycle into output register when not stalled.
// ----------------------------------------------------------------------------
module cqt_back import cqt_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         q_rvalid,
    input  quad_t        q_rdata,
    output logic         q_pop,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,
    output logic         m_tlast,
    output logic         m_tuser
);

    localparam qtab_t QTAB = build_qtab();

    function automatic logic signed [15:0] tab_sin(logic [AW-1:0] a);
        logic [1:0]      qd;
        logic [AW-3:0]   r;
        logic [AW-2:0]   idx;
        logic [VALW-1:0] m;
        qd  = a[AW-1:AW-2];
        r   = a[AW-3:0];
        idx = qd[0] ? ((AW-1)'(QUARTER) - {1'b0, r}) : {1'b0, r};
        m   = QTAB[idx];
        return qd[1] ? -$signed({1'b0, m}) : $signed({1'b0, m});
    endfunction

    function automatic logic signed [15:0] round_q14(logic [29:0] p, logic neg);
        logic [15:0] v;
        v = 16'((31'(p) + 31'(HALF_Q14)) >> 14);
        return neg ? -$signed(v) : $signed(v);
    endfunction

    logic adv, issue;
    logic [2:0] k_reg, k_next;

    logic        s1_vld_reg, s1_err_reg, s1_last_reg;
    logic [2:0]  s1_k_reg;
    logic [1:0]  s1_part_reg;
    logic signed [15:0] s1_sin_reg, s1_cos_reg, s1_y_reg;
    logic [VALW-1:0] s1_rad_reg;

    logic        s2_vld_reg, s2_err_reg, s2_last_reg;
    logic [2:0]  s2_k_reg;
    logic [1:0]  s2_part_reg;
    logic signed [15:0] s2_sin_reg, s2_cos_reg, s2_y_reg;
    logic [29:0] s2_px_reg, s2_pz_reg;

    logic         out_vld_reg, out_last_reg, out_err_reg;
    logic [103:0] out_data_reg, out_data_next;

    logic [1:0]      cid;
    logic            side, outer;
    logic [AW-1:0]   ang;
    logic [VALW-1:0] rv;
    logic signed [15:0] y0;
    logic [14:0] sin_mag, cos_mag;
    logic signed [15:0] px, pz, nx, ny, nz;

    assign adv    = !out_vld_reg || m_tready;
    assign issue  = q_rvalid && adv;
    assign q_pop  = issue && (q_rdata.err || (k_reg == 3'd5));
    assign k_next = q_pop ? 3'd0 : (issue ? (k_reg + 3'd1) : k_reg);

    always_comb begin
        cid   = corner_of(k_reg, q_rdata.part == OP_BOTTOM);
        side  = (q_rdata.part == OP_SIDE);
        outer = (cid == CORNER_BL) || (cid == CORNER_BR);
        ang   = ((cid == CORNER_TR) || (cid == CORNER_BR)) ? q_rdata.a1 : q_rdata.a0;
        rv    = outer ? q_rdata.v1 : q_rdata.v0;
        if (side) begin
            y0 = 16'(HALF_Q14) - $signed({1'b0, rv});
        end else if (q_rdata.part == OP_TOP) begin
            y0 = 16'(HALF_Q14);
        end else begin
            y0 = -16'(HALF_Q14);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg       <= 3'd0;
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            k_reg <= k_next;
            if (adv) begin
                s1_vld_reg  <= issue;
                s2_vld_reg  <= s1_vld_reg;
                out_vld_reg <= s2_vld_reg;
            end
        end
        if (adv) begin
            s1_err_reg  <= q_rdata.err;
            s1_last_reg <= q_rdata.err || (k_reg == 3'd5);
            s1_k_reg    <= k_reg;
            s1_part_reg <= q_rdata.part;
            s1_sin_reg  <= tab_sin(ang);
            s1_cos_reg  <= tab_sin(ang + AW'(QUARTER));
            s1_y_reg    <= y0;
            s1_rad_reg  <= side ? VALW'(HALF_Q14) : rv;

            s2_err_reg  <= s1_err_reg;
            s2_last_reg <= s1_last_reg;
            s2_k_reg    <= s1_k_reg;
            s2_part_reg <= s1_part_reg;
            s2_sin_reg  <= s1_sin_reg;
            s2_cos_reg  <= s1_cos_reg;
            s2_y_reg    <= s1_y_reg;
            s2_px_reg   <= s1_rad_reg * sin_mag;
            s2_pz_reg   <= s1_rad_reg * cos_mag;

            out_err_reg  <= s2_err_reg;
            out_last_reg <= s2_last_reg;
            out_data_reg <= out_data_next;
        end
    end

    always_comb begin
        sin_mag = s1_sin_reg[15] ? 15'(-s1_sin_reg) : s1_sin_reg[14:0];
        cos_mag = s1_cos_reg[15] ? 15'(-s1_cos_reg) : s1_cos_reg[14:0];
        px = round_q14(s2_px_reg, s2_sin_reg[15]);
        pz = round_q14(s2_pz_reg, s2_cos_reg[15]);
        if (s2_part_reg == OP_SIDE) begin
            nx = s2_sin_reg;
            ny = '0;
            nz = s2_cos_reg;
        end else begin
            nx = '0;
            ny = (s2_part_reg == OP_TOP) ? 16'(ONE_Q14) : -16'(ONE_Q14);
            nz = '0;
        end
        if (s2_err_reg) begin
            out_data_next = '0;
        end else begin
            out_data_next = {5'd0, s2_k_reg, nz, ny, nx, pz, s2_y_reg, px};
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_err_reg;

endmodule

[rtl/cylinder_quad_tessellator.sv]
// ----------------------------------------------------------------------------
// cylinder_quad_tessellator
// One quad of a cylinder mesh per request: six vertices with position and
// normal in Q1.14, or a single error item for indices out of range or OP_NONE.
//
//   channel   direction   handshake          payload
//   s_        in          tvalid/tready      tdata: wedge, segment; tuser: part
//   m_        out         tvalid/tready      tdata: vertex; tlast; tuser: error
//   apb       in          psel/penable       height_segments, angle_segments
//
// The back end gives one vertex a cycle while m_tready does not stall it, and
// a single item for an error request. The front takes no new request until
// it has issued the four divides of the last one into the shared pipelined
// divider.
// Reset is synchronous and active low; it empties divider, queue and pipeline.
// A stall on m_tready holds the back pipeline; a four-quad queue keeps the
// front accepting meanwhile.
// ----------------------------------------------------------------------------
module cylinder_quad_tessellator import cqt_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [15:0]  s_tdata,   // wedge_index[7:0], segment_index[15:8]
    input  logic [1:0]   s_tuser,   // opcode[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                                    // corner_number[98:96]
    output logic         m_tlast,
    output logic         m_tuser,   // index_error
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [7:0] height_reg, height_next;
    logic [7:0] angle_reg, angle_next;
    logic       cfg_wr;
    logic [7:0] wval;
    logic       q_push, q_pop, q_rvalid;
    quad_t      q_wdata, q_rdata;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign wval   = pwdata[7:0];
    assign prdata = {24'd0, (paddr[2] == REG_ANGLE) ? angle_reg : height_reg};

    always_comb begin
        height_next = height_reg;
        angle_next  = angle_reg;
        if (cfg_wr) begin
            if (paddr[2] == REG_HEIGHT) begin
                height_next = (12'(wval) > 12'(MAX_HEIGHT_SEGMENTS)) ?
                              8'(MAX_HEIGHT_SEGMENTS) : wval;
            end else begin
                angle_next = (12'(wval) > 12'(MAX_ANGLE_SEGMENTS)) ?
                             8'(MAX_ANGLE_SEGMENTS) : wval;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            height_reg <= 8'd1;
            angle_reg  <= 8'd8;
        end else begin
            height_reg <= height_next;
            angle_reg  <= angle_next;
        end
    end

    cqt_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .height_segments (height_reg),
        .angle_segments  (angle_reg),
        .q_pop           (q_pop),
        .q_push          (q_push),
        .q_wdata         (q_wdata)
    );

    cqt_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .pop     (q_pop),
        .rvalid  (q_rvalid),
        .rdata   (q_rdata)
    );

    cqt_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_rvalid (q_rvalid),
        .q_rdata  (q_rdata),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

[rtl/cqt_checker.sv]
// ----------------------------------------------------------------------------
// cqt_checker
// Port-level checks on the result channel of the tessellator.
// ----------------------------------------------------------------------------
module cqt_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [103:0] m_tdata,
    input logic         m_tlast,
    input logic         m_tuser
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    a_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast && (m_tdata == '0))
        else $error("error item malformed");

    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast && !m_tuser |-> (m_tdata[98:96] == 3'd5))
        else $error("quad ended before sixth vertex");

    a_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=>
            !m_tvalid || (m_tdata[98:96] == $past(m_tdata[98:96]) + 3'd1))
        else $error("corner number out of sequence");

endmodule

bind cylinder_quad_tessellator cqt_checker u_cqt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

[dv/cylinder_quad_checker.sv]
// ----------------------------------------------------------------------------
// cylinder_quad_checker
// Watches the request and vertex channels of the cylinder quad tessellator,
// computes the six vertices (or the error item) each accepted request should
// give, and compares every vertex item field by field in order.
// ----------------------------------------------------------------------------
module cylinder_quad_checker import cqt_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [15:0]  s_tdata,
    input  logic [1:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [103:0] m_tdata,
    input  logic         m_tlast,
    input  logic         m_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output int           fail_count,
    output int           pending
);

    typedef struct {
        logic signed [15:0] v [6];
        logic [2:0]         corner;
        logic               last;
        logic               err;
    } vertex_t;

    vertex_t vertex_q [$];
    int      sine_q14 [QUARTER+1];
    int      height_cfg;
    int      angle_cfg;

    assign pending = vertex_q.size();

    function automatic string field_name(int j);
        case (j)
            0: return "pos_x";
            1: return "pos_y";
            2: return "pos_z";
            3: return "norm_x";
            4: return "norm_y";
            default: return "norm_z";
        endcase
    endfunction

    function automatic int sine_entry(int k);
        longint unsigned x;
        longint unsigned sum;
        longint unsigned term;
        longint unsigned r;
        x = (64'd1686629713 * k) / QUARTER;
        sum = x;
        term = x;
        for (int n = 1; n <= 8; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / ((2 * n) * (2 * n + 1));
            if (n % 2) sum = sum - term;
            else sum = sum + term;
        end
        r = (sum * 16384 + (64'd1 << 29)) >> 30;
        if (r > 16384) r = 16384;
        return int'(r);
    endfunction

    function automatic int lookup_sin(int a);
        int q;
        int r;
        a = a & (4 * QUARTER - 1);
        q = a / QUARTER;
        r = a % QUARTER;
        case (q)
            0: return sine_q14[r];
            1: return sine_q14[QUARTER - r];
            2: return -sine_q14[r];
            default: return -sine_q14[QUARTER - r];
        endcase
    endfunction

    function automatic int round_scale(int r, int s);
        longint p;
        longint m;
        p = longint'(r) * s;
        m = (p < 0) ? -p : p;
        m = (m + HALF_Q14) >>> 14;
        return (p < 0) ? -int'(m) : int'(m);
    endfunction

    function automatic int wedge_angle(int w);
        return ((w * 4 * QUARTER + angle_cfg / 2) / angle_cfg) & (4 * QUARTER - 1);
    endfunction

    task automatic predict_quad(int w, logic [1:0] op, int c);
        int      pt [4][6];
        int      a0;
        int      a1;
        int      s0, c0, s1, c1, h, y0, y1, ny;
        int      corner_sel;
        vertex_t vx;
        if (op == OP_NONE || w >= angle_cfg || c >= height_cfg) begin
            foreach (vx.v[j]) vx.v[j] = '0;
            vx.corner = '0;
            vx.last = 1'b1;
            vx.err = 1'b1;
            vertex_q.insert(vertex_q.size(), vx);
            return;
        end
        h = height_cfg;
        a0 = wedge_angle(w);
        a1 = wedge_angle(w + 1);
        s0 = lookup_sin(a0);
        c0 = lookup_sin(a0 + QUARTER);
        s1 = lookup_sin(a1);
        c1 = lookup_sin(a1 + QUARTER);
        if (op == OP_SIDE) begin
            y0 = HALF_Q14 - (c * ONE_Q14 + h / 2) / h;
            y1 = HALF_Q14 - ((c + 1) * ONE_Q14 + h / 2) / h;
            pt[CORNER_TL] = '{round_scale(HALF_Q14, s0), y0, round_scale(HALF_Q14, c0),
                              s0, 0, c0};
            pt[CORNER_BL] = '{round_scale(HALF_Q14, s0), y1, round_scale(HALF_Q14, c0),
                              s0, 0, c0};
            pt[CORNER_TR] = '{round_scale(HALF_Q14, s1), y0, round_scale(HALF_Q14, c1),
                              s1, 0, c1};
            pt[CORNER_BR] = '{round_scale(HALF_Q14, s1), y1, round_scale(HALF_Q14, c1),
                              s1, 0, c1};
        end else begin
            y0 = (c * HALF_Q14 + h / 2) / h;
            y1 = ((c + 1) * HALF_Q14 + h / 2) / h;
            ny = (op == OP_TOP) ? ONE_Q14 : -ONE_Q14;
            h = (op == OP_TOP) ? HALF_Q14 : -HALF_Q14;
            pt[CORNER_TL] = '{round_scale(y0, s0), h, round_scale(y0, c0), 0, ny, 0};
            pt[CORNER_BL] = '{round_scale(y1, s0), h, round_scale(y1, c0), 0, ny, 0};
            pt[CORNER_TR] = '{round_scale(y0, s1), h, round_scale(y0, c1), 0, ny, 0};
            pt[CORNER_BR] = '{round_scale(y1, s1), h, round_scale(y1, c1), 0, ny, 0};
        end
        for (int k = 0; k < 6; k++) begin
            case (k)
                0: corner_sel = (op == OP_BOTTOM) ? CORNER_BL : CORNER_TL;
                1: corner_sel = (op == OP_BOTTOM) ? CORNER_TL : CORNER_BL;
                2: corner_sel = CORNER_TR;
                3: corner_sel = (op == OP_BOTTOM) ? CORNER_BR : CORNER_BL;
                4: corner_sel = (op == OP_BOTTOM) ? CORNER_BL : CORNER_BR;
                default: corner_sel = CORNER_TR;
            endcase
            foreach (vx.v[j]) vx.v[j] = 16'(pt[corner_sel][j]);
            vx.corner = 3'(k);
            vx.last = (k == 5);
            vx.err = 1'b0;
            vertex_q.insert(vertex_q.size(), vx);
        end
    endtask

    initial begin
        for (int k = 0; k <= QUARTER; k++) sine_q14[k] = sine_entry(k);
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            height_cfg <= 1;
            angle_cfg <= 8;
            fail_count <= 0;
            vertex_q.delete();
        end else begin
            if (psel && penable && pwrite) begin
                if (paddr == 3'(REG_HEIGHT) * 4) height_cfg <= int'(pwdata[7:0]);
                if (paddr == 3'(REG_ANGLE) * 4) angle_cfg <= int'(pwdata[7:0]);
            end
            if (m_tvalid && m_tready) begin
                if (vertex_q.size() == 0) begin
                    $error("vertex item with none expected");
                    fail_count <= fail_count + 1;
                end else begin
                    automatic vertex_t ex = vertex_q.pop_front();
                    automatic int bad = 0;
                    foreach (ex.v[j]) begin
                        if (m_tdata[16*j +: 16] !== ex.v[j]) begin
                            $error("%s: expected %0d, got %0d", field_name(j),
                                   ex.v[j], $signed(m_tdata[16*j +: 16]));
                            bad++;
                        end
                    end
                    if (m_tdata[98:96] !== ex.corner) begin
                        $error("corner_number: expected %0d, got %0d", ex.corner,
                               m_tdata[98:96]);
                        bad++;
                    end
                    if (m_tlast !== ex.last) begin
                        $error("last: expected %0d, got %0d", ex.last, m_tlast);
                        bad++;
                    end
                    if (m_tuser !== ex.err) begin
                        $error("index_error: expected %0d, got %0d", ex.err, m_tuser);
                        bad++;
                    end
                    if (bad) fail_count <= fail_count + 1;
                end
            end
            if (s_tvalid && s_tready) begin
                predict_quad(s_tdata[7:0], s_tuser, s_tdata[15:8]);
            end
        end
    end

endmodule

[dv/cylinder_quad_tessellator_tb.sv]
// ----------------------------------------------------------------------------
// cylinder_quad_tessellator_tb
// Drives quad requests through several segment settings, with bursty
// requests and a vertex sink that stalls in all but one phase; a checker
// beside the block compares every vertex item.
// ----------------------------------------------------------------------------
module cylinder_quad_tessellator_tb import cqt_pkg::*;;

    localparam int IDLE_LIMIT = 20000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [15:0]  s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;
    logic         m_tlast;
    logic         m_tuser;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;
    int           fail_count;
    int           pending;
    int           idle_cycles = 0;
    int           height_now = 1;
    int           angle_now = 8;
    bit           sink_stalls = 1'b1;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    cylinder_quad_tessellator i_dut (.*);

    cylinder_quad_checker i_checker (.*);

    always @(posedge aclk) begin
        if (!sink_stalls) m_tready <= 1'b1;
        else m_tready <= ($urandom_range(0, 7) < 5);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic write_reg(logic reg_sel, int value);
        @(posedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {reg_sel, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (reg_sel == REG_HEIGHT) height_now = value;
        else angle_now = value;
    endtask

    task automatic send_request(int w, logic [1:0] op, int c);
        s_tvalid <= 1'b1;
        s_tdata <= {8'(c), 8'(w)};
        s_tuser <= op;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    task automatic random_burst(int count);
        int w;
        int c;
        logic [1:0] op;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 3) == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
            w = (angle_now > 0) ? $urandom_range(0, angle_now - 1) : 0;
            c = (height_now > 0) ? $urandom_range(0, height_now - 1) : 0;
            op = 2'($urandom_range(0, 2));
            if ($urandom_range(0, 9) == 0) begin
                w = $urandom_range(0, 255);
                c = $urandom_range(0, 255);
                op = 2'($urandom_range(0, 3));
            end
            send_request(w, op, c);
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        send_request(0, OP_SIDE, 0);
        send_request(7, OP_TOP, 0);
        send_request(3, OP_BOTTOM, 0);
        send_request(8, OP_SIDE, 0);
        send_request(0, OP_SIDE, 1);
        send_request(0, OP_NONE, 0);
        send_request(255, OP_NONE, 255);
        drain();
        write_reg(REG_HEIGHT, 255);
        write_reg(REG_ANGLE, 255);
        send_request(254, OP_SIDE, 254);
        send_request(254, OP_TOP, 254);
        send_request(254, OP_BOTTOM, 254);
        send_request(0, OP_BOTTOM, 0);
        send_request(127, OP_SIDE, 128);
        send_request(170, OP_TOP, 85);
        send_request(85, OP_BOTTOM, 170);
        send_request(255, OP_SIDE, 0);
        send_request(0, OP_SIDE, 255);
        drain();
        write_reg(REG_HEIGHT, 0);
        write_reg(REG_ANGLE, 1);
        send_request(0, OP_SIDE, 0);
        send_request(0, OP_TOP, 0);
        drain();
        write_reg(REG_HEIGHT, 1);
        write_reg(REG_ANGLE, 0);
        send_request(0, OP_BOTTOM, 0);
        drain();
        write_reg(REG_ANGLE, 1);
        send_request(0, OP_SIDE, 0);
        send_request(0, OP_TOP, 0);
        send_request(0, OP_BOTTOM, 0);
        drain();
        write_reg(REG_HEIGHT, 3);
        write_reg(REG_ANGLE, 12);
        random_burst(50);
        drain();
        write_reg(REG_HEIGHT, $urandom_range(1, 255));
        write_reg(REG_ANGLE, $urandom_range(1, 255));
        random_burst(50);
        drain();
        sink_stalls = 1'b0;
        write_reg(REG_HEIGHT, 255);
        write_reg(REG_ANGLE, 255);
        random_burst(40);
        drain();
        sink_stalls = 1'b1;
        write_reg(REG_HEIGHT, 16);
        write_reg(REG_ANGLE, 2);
        random_burst(50);
        drain();
        if (fail_count == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end

endmodule

[sim.f]
rtl/cqt_pkg.sv
rtl/cqt_div.sv
rtl/cqt_front.sv
rtl/cqt_queue.sv
rtl/cqt_back.sv
rtl/cylinder_quad_tessellator.sv
rtl/cqt_checker.sv
dv/cylinder_quad_checker.sv
dv/cylinder_quad_tessellator_tb.sv
